/* hdl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, payload words, codes and control structs of the frame
// bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int BITMAP_WORDS = 1024;
  localparam int FRAME_SHIFT  = 12;

  localparam int WORD_BITS   = 32;
  localparam int BIT_AW      = 5;
  localparam int WORD_AW     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int FRAME_IDX_W = WORD_AW + BIT_AW;
  localparam int FRAME_NUM_W = 32 - FRAME_SHIFT;
  localparam int CFG_W       = 16;
  localparam int CFG_AW      = 2;
  localparam int CMD_W       = 3;
  localparam int FOUND_W     = 27;

  localparam logic [31:0] CAP = 32'(BITMAP_WORDS * WORD_BITS);
  localparam int EFF_W = (BITMAP_WORDS * WORD_BITS > 65535) ? CFG_W :
                         $clog2(BITMAP_WORDS * WORD_BITS + 1);

  localparam logic [CFG_W-1:0]  FRAME_COUNT_RST     = 16'd32768;
  localparam logic [CFG_AW-1:0] REG_FRAME_COUNT_ADR = 2'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 3'd0,
    CMD_CLR   = 3'd1,
    CMD_TEST  = 3'd2,
    CMD_FIND  = 3'd3,
    CMD_ALLOC = 3'd4
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOFREE = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [31:0]      frame_addr;
  } in_word_t;

  typedef struct packed {
    logic [FOUND_W-1:0] found_addr;
    logic               was_used;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_frame;
    logic rd_scan;
    logic wr_frame;
    logic wr_found;
    logic res_range;
    logic res_nofree;
    logic res_used;
    logic res_found;
    logic out_load;
  } fba_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_rmw;
    logic is_find;
    logic is_set;
    logic is_clr;
    logic is_alloc;
    logic in_range;
    logic lim_zero;
    logic word_full;
    logic hit;
    logic chk_last;
  } fba_sts_t;

endpackage

/* hdl/fba_dp.sv */
// ----------------------------------------------------------------------------
// fba_dp
// Bitmap memory, request registers, word scan pointer, lowest-zero search
// and result registers.
// ----------------------------------------------------------------------------
module fba_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fba_pkg::fba_cmd_t            ctl,
  output fba_pkg::fba_sts_t            sts,
  input  fba_pkg::in_word_t            in_data,
  input  logic [fba_pkg::EFF_W-1:0]    limit,
  output fba_pkg::out_word_t           out_data
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0]   mem [BITMAP_WORDS];
  logic [WORD_BITS-1:0]   rd_data_r;
  logic [CMD_W-1:0]       cmd_r;
  logic [FRAME_NUM_W-1:0] frame_r;
  logic [WORD_AW-1:0]     ptr_r;
  logic [WORD_AW-1:0]     chk_r;
  logic [FOUND_W-1:0]     res_found_r;
  logic                   res_used_r;
  logic [1:0]             res_status_r;
  out_word_t              out_data_r;

  logic [WORD_AW-1:0]     frame_word;
  logic [BIT_AW-1:0]      frame_bit;
  logic [WORD_BITS-1:0]   frame_mask;
  logic [31:0]            lim32;
  logic [31:0]            lim_m1;
  logic [WORD_AW-1:0]     last_word;
  logic [3:0]             byte_zero;
  logic [1:0]             zbyte;
  logic [2:0]             zbit;
  logic [7:0]             sel_byte;
  logic [BIT_AW-1:0]      zpos;
  logic [FRAME_IDX_W-1:0] found_frame;
  logic [31:0]            found_shift;
  logic [WORD_BITS-1:0]   zmask;
  logic                   mem_we;
  logic                   mem_re;
  logic [WORD_AW-1:0]     mem_wa;
  logic [WORD_AW-1:0]     mem_ra;
  logic [WORD_BITS-1:0]   mem_wd;

  assign frame_word = frame_r[FRAME_IDX_W-1:BIT_AW];
  assign frame_bit  = frame_r[BIT_AW-1:0];
  assign frame_mask = WORD_BITS'(1) << frame_bit;
  assign lim32      = 32'(limit);
  assign lim_m1     = lim32 - 32'd1;
  assign last_word  = lim_m1[FRAME_IDX_W-1:BIT_AW];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      byte_zero[b] = ~&rd_data_r[8*b +: 8];
    end
    zbyte = 2'd0;
    for (int b = 3; b >= 0; b--) begin
      if (byte_zero[b]) begin
        zbyte = 2'(b);
      end
    end
    sel_byte = rd_data_r[8*zbyte +: 8];
    zbit = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!sel_byte[k]) begin
        zbit = 3'(k);
      end
    end
  end

  assign zpos        = {zbyte, zbit};
  assign zmask       = WORD_BITS'(1) << zpos;
  assign found_frame = {chk_r, zpos};
  assign found_shift = 32'(found_frame) << FRAME_SHIFT;

  always_comb begin
    sts.clr_done  = (ptr_r == WORD_AW'(BITMAP_WORDS - 1));
    sts.is_rmw    = cmd_r inside {CMD_SET, CMD_CLR, CMD_TEST};
    sts.is_find   = cmd_r inside {CMD_FIND, CMD_ALLOC};
    sts.is_set    = (cmd_r == CMD_SET);
    sts.is_clr    = (cmd_r == CMD_CLR);
    sts.is_alloc  = (cmd_r == CMD_ALLOC);
    sts.in_range  = (32'(frame_r) < lim32);
    sts.lim_zero  = (lim32 == 32'd0);
    sts.word_full = &rd_data_r;
    sts.hit       = (32'(found_frame) < lim32);
    sts.chk_last  = (chk_r == last_word);
  end

  always_comb begin
    mem_re = ctl.rd_frame | ctl.rd_scan;
    mem_ra = ctl.rd_frame ? frame_word : ptr_r;
    mem_we = ctl.clr_step | ctl.wr_frame | ctl.wr_found;
    if (ctl.clr_step) begin
      mem_wa = ptr_r;
      mem_wd = '0;
    end else if (ctl.wr_frame) begin
      mem_wa = frame_word;
      mem_wd = (cmd_r == CMD_SET) ? (rd_data_r | frame_mask) : (rd_data_r & ~frame_mask);
    end else begin
      mem_wa = chk_r;
      mem_wd = rd_data_r | zmask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (ctl.load) begin
      ptr_r <= '0;
    end else if (ctl.clr_step || ctl.rd_scan) begin
      ptr_r <= ptr_r + WORD_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_scan) begin
      chk_r <= ptr_r;
    end
    if (ctl.load) begin
      cmd_r        <= in_data.cmd;
      frame_r      <= in_data.frame_addr[31:FRAME_SHIFT];
      res_found_r  <= '0;
      res_used_r   <= 1'b0;
      res_status_r <= ST_OK;
    end
    if (ctl.res_range) begin
      res_status_r <= ST_RANGE;
    end
    if (ctl.res_nofree) begin
      res_status_r <= ST_NOFREE;
    end
    if (ctl.res_used) begin
      res_used_r <= rd_data_r[frame_bit];
    end
    if (ctl.res_found) begin
      res_found_r <= found_shift[FOUND_W-1:0];
    end
    if (ctl.out_load) begin
      out_data_r.found_addr <= res_found_r;
      out_data_r.was_used   <= res_used_r;
      out_data_r.status     <= res_status_r;
    end
  end

  assign out_data = out_data_r;

endmodule

/* hdl/fba_ctrl.sv */
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer of the allocator: clearing pass, dispatch, read-modify-write,
// word scan and result handoff.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fba_pkg::fba_cmd_t ctl,
  input  fba_pkg::fba_sts_t sts
);
  import fba_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_rmw) begin
          if (sts.in_range) begin
            ctl.rd_frame = 1'b1;
            state_nxt    = S_MOD;
          end else begin
            ctl.res_range = 1'b1;
            state_nxt     = S_FIN;
          end
        end else if (sts.is_find) begin
          if (sts.lim_zero) begin
            ctl.res_nofree = 1'b1;
            state_nxt      = S_FIN;
          end else begin
            ctl.rd_scan = 1'b1;
            state_nxt   = S_SCAN;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MOD: begin
        ctl.res_used = 1'b1;
        ctl.wr_frame = sts.is_set | sts.is_clr;
        state_nxt    = S_FIN;
      end
      S_SCAN: begin
        if (sts.word_full) begin
          if (sts.chk_last) begin
            ctl.res_nofree = 1'b1;
            state_nxt      = S_FIN;
          end else begin
            ctl.rd_scan = 1'b1;
          end
        end else if (sts.hit) begin
          ctl.res_found = 1'b1;
          ctl.wr_found  = sts.is_alloc;
          state_nxt     = S_FIN;
        end else begin
          ctl.res_nofree = 1'b1;
          state_nxt      = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/frame_bitmap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit
// Page frame allocator over a bitmap of frames, one bit per frame, with
// mark, free, test, find and allocate requests.
// ----------------------------------------------------------------------------
//   port group   | dir     | word
//   in_*         | in      | in_word_t  {cmd, frame_addr}
//   out_*        | out     | out_word_t {found_addr, was_used, status}
//   p* (APB)     | in/out  | frame_count at byte 0
//
// In-range mark, free and test step through dispatch, read-modify-write
// and finish. Out of range, unknown command and zero-count find go from
// dispatch to finish. Find and allocate scan the bitmap words in turn,
// one memory read per cycle through the single bitmap read port.
// After reset a clearing pass zeroes the bitmap; no word is taken meanwhile.
// A new word is taken while a finished result waits in the output register;
// its final cycle holds until that result is taken.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fba_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fba_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fba_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fba_pkg::*;

  logic [CFG_W-1:0] frame_count_r;
  logic [EFF_W-1:0] limit;
  fba_cmd_t         ctl;
  fba_sts_t         sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr == REG_FRAME_COUNT_ADR)) begin
      frame_count_r <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_FRAME_COUNT_ADR) ? 32'(frame_count_r) : 32'd0;
  assign limit  = (32'(frame_count_r) > CAP) ? EFF_W'(CAP) : EFF_W'(frame_count_r);

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  fba_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sts      (sts),
    .in_data  (in_data),
    .limit    (limit),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word taken while another is in flight");

  a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_NOFREE)) |-> (out_data.found_addr == '0))
    else $error("no-free result carries an address");

  a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_RANGE)) |->
      (!out_data.was_used && (out_data.found_addr == '0)))
    else $error("out-of-range result carries data");
`endif

endmodule
